// ----- rtl/ksc_pkg.sv -----
// Package for the kana script converter: code point constants, vowel class
// table and lookup function, direction codes and the input word type.
// No dependencies.
package ksc_pkg;

	// Code point and vowel class types
	typedef logic [20:0] code_t;
	typedef logic [2:0]  vowel_t;

	// Direction register codes
	typedef enum logic {
		DIR_HIRA_TO_KATA = 1'b0,
		DIR_KATA_TO_HIRA = 1'b1
	} dir_t;

	// Vowel classes
	localparam vowel_t VOWEL_NONE = 3'd0;
	localparam vowel_t VOWEL_A    = 3'd1;
	localparam vowel_t VOWEL_I    = 3'd2;
	localparam vowel_t VOWEL_U    = 3'd3;
	localparam vowel_t VOWEL_E    = 3'd4;
	localparam vowel_t VOWEL_O    = 3'd5;

	// Code point ranges and marks
	localparam code_t HIRA_START     = 21'h03041;
	localparam code_t HIRA_END       = 21'h03096;
	localparam code_t HIRA_TABLE_END = 21'h03093;
	localparam code_t KATA_START     = 21'h030A1;
	localparam code_t KATA_CONV_END  = 21'h030F4;
	localparam code_t KATA_TABLE_END = 21'h030F3;
	localparam code_t KATA_TAIL_END  = 21'h030FA;
	localparam code_t SMALL_KA       = 21'h030F5;
	localparam code_t SMALL_KE       = 21'h030F6;
	localparam code_t PROLONGED_MARK = 21'h030FC;
	localparam code_t SCRIPT_OFFSET  = 21'h00060;

	// Hiragana vowels that replace the prolonged mark
	localparam code_t HIRA_A = 21'h03042;
	localparam code_t HIRA_I = 21'h03044;
	localparam code_t HIRA_U = 21'h03046;
	localparam code_t HIRA_E = 21'h03048;

	localparam int TABLE_LEN = 83;

	// Vowel classes of 0x3041..0x3093 (same layout for katakana 0x30A1..0x30F3)
	localparam vowel_t KANA_VOWEL [0:TABLE_LEN-1] = '{
		3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5,
		3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5,
		3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5,
		3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5,
		3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
		3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3,
		3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5,
		3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
		3'd1, 3'd1, 3'd3, 3'd3, 3'd5, 3'd5,
		3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
		3'd1, 3'd1, 3'd2, 3'd4, 3'd5, 3'd0
	};

	// Classes of katakana 0x30F4..0x30FA
	localparam vowel_t KATA_TAIL_VOWEL [0:6] = '{
		3'd3, 3'd1, 3'd4, 3'd1, 3'd2, 3'd4, 3'd5
	};

	// One input word
	typedef struct packed {
		code_t code_point;
		logic  start_of_text;
	} item_t;

	// Vowel class of a code point, none for anything outside the kana tables
	function automatic vowel_t vowel_of(input code_t c);
		code_t  off;
		vowel_t v;
		v = VOWEL_NONE;
		off = '0;
		if (c >= HIRA_START && c <= HIRA_TABLE_END) begin
			off = c - HIRA_START;
			v = KANA_VOWEL[off[6:0]];
		end else if (c >= KATA_START && c <= KATA_TABLE_END) begin
			off = c - KATA_START;
			v = KANA_VOWEL[off[6:0]];
		end else if (c >= KATA_CONV_END && c <= KATA_TAIL_END) begin
			off = c - KATA_CONV_END;
			v = KATA_TAIL_VOWEL[off[2:0]];
		end
		return v;
	endfunction

endpackage

// ----- rtl/kana_script_converter.sv -----
// Top level of the kana script converter: input register, conversion stage,
// output register, vowel class state and direction register.
// Depends on ksc_pkg and ksc_convert.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  input   | in_valid, in_stall, code_point,       | in
//          | start_of_text                         |
//  output  | out_valid, out_stall, converted_point | out
//  config  | cfg_valid, cfg_ready, direction       | in
//
// One word per cycle while the output is not held. An accepted word goes into
// the input register, then into the output register, from which it can leave;
// a held output can keep it in the input register. The conversion and the
// vowel class update are combinational between the two registers.
// Reset clears both valid flags, the vowel class and the direction (hiragana
// to katakana). A held output stalls the input register, and the input
// stalls only when both registers are full and the output is held.
module kana_script_converter (
	input  logic           clk,
	input  logic           arst_n,
	// input channel
	input  logic           in_valid,
	output logic           in_stall,
	input  ksc_pkg::code_t code_point,
	input  logic           start_of_text,
	// output channel
	output logic           out_valid,
	input  logic           out_stall,
	output ksc_pkg::code_t converted_point,
	// configuration channel
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           direction
);
	import ksc_pkg::*;

	logic   valid_s1;
	item_t  item_s1;
	logic   valid_s2;
	code_t  result_s2;
	vowel_t prev_vowel_q;
	dir_t   dir_q;
	code_t  result;
	vowel_t result_vowel;
	logic   adv_s2;
	logic   adv_s1;

	// stage movement
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_stall = valid_s1 && !adv_s2;

	assign cfg_ready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_HIRA_TO_KATA;
		end else if (cfg_valid && cfg_ready) begin
			dir_q <= dir_t'(direction);
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.code_point    <= code_point;
			item_s1.start_of_text <= start_of_text;
		end
	end

	ksc_convert u_convert (
		.item         (item_s1),
		.dir          (dir_q),
		.prev_vowel   (prev_vowel_q),
		.result       (result),
		.result_vowel (result_vowel)
	);

	// output register and remembered vowel class
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			prev_vowel_q <= VOWEL_NONE;
		end else begin
			if (adv_s2)
				valid_s2 <= valid_s1;
			if (adv_s1)
				prev_vowel_q <= result_vowel;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			result_s2 <= result;
	end

	assign out_valid       = valid_s2;
	assign converted_point = result_s2;

endmodule

// ----- rtl/ksc_convert.sv -----
// Conversion logic for one code point: script shift, prolonged mark
// expansion and the vowel class of the result. Purely combinational.
// Depends on ksc_pkg.
module ksc_convert (
	input  ksc_pkg::item_t  item,
	input  ksc_pkg::dir_t   dir,
	input  ksc_pkg::vowel_t prev_vowel,
	output ksc_pkg::code_t  result,
	output ksc_pkg::vowel_t result_vowel
);
	import ksc_pkg::*;

	code_t  c;
	vowel_t prev_eff;
	code_t  prolonged;

	assign c = item.code_point;

	// start of text clears the remembered class before this word
	assign prev_eff = item.start_of_text ? VOWEL_NONE : prev_vowel;

	// replacement for the prolonged mark, unchanged when there is no class
	always_comb begin
		unique case (prev_eff)
			VOWEL_A: prolonged = HIRA_A;
			VOWEL_I: prolonged = HIRA_I;
			VOWEL_U: prolonged = HIRA_U;
			VOWEL_E: prolonged = HIRA_E;
			VOWEL_O: prolonged = HIRA_U;
			default: prolonged = c;
		endcase
	end

	// script conversion
	always_comb begin
		result = c;
		unique case (dir)
			DIR_HIRA_TO_KATA: begin
				if (c >= HIRA_START && c <= HIRA_END)
					result = c + SCRIPT_OFFSET;
			end
			DIR_KATA_TO_HIRA: begin
				priority if (c == SMALL_KA || c == SMALL_KE)
					result = c;
				else if (c == PROLONGED_MARK)
					result = prolonged;
				else if (c >= KATA_START && c <= KATA_CONV_END)
					result = c - SCRIPT_OFFSET;
				else
					result = c;
			end
			default: result = c;
		endcase
	end

	// class of this output, remembered for the next word
	assign result_vowel = vowel_of(result);

endmodule

// ----- dv/tb.sv -----
// Testbench for kana_script_converter: random and directed code point streams
// checked word by word against a kana conversion tracker kept in the bench.
// Depends on ksc_pkg and the converter RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ksc_pkg::*;

	localparam int HOLD_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_WORDS    = 166;

	// Tracks direction and remembered vowel, predicts each converted word
	class kana_conversion_tracker;
		dir_t   mode;
		vowel_t last_vowel;
		code_t  expected_points [$];
		int     errors;
		int     kana_vowels [0:82];
		int     tail_vowels [0:6];

		function new();
			mode = DIR_HIRA_TO_KATA;
			last_vowel = VOWEL_NONE;
			errors = 0;
			// classes of 0x3041..0x3093, same layout for katakana from 0x30A1
			kana_vowels = '{
				1, 1, 2, 2, 3, 3, 4, 4, 5, 5,
				1, 1, 2, 2, 3, 3, 4, 4, 5, 5,
				1, 1, 2, 2, 3, 3, 4, 4, 5, 5,
				1, 1, 2, 2, 3, 3, 3, 4, 4, 5, 5,
				1, 2, 3, 4, 5,
				1, 1, 1, 2, 2, 2, 3, 3, 3, 4, 4, 4, 5, 5, 5,
				1, 2, 3, 4, 5,
				1, 1, 3, 3, 5, 5,
				1, 2, 3, 4, 5,
				1, 1, 2, 4, 5, 0
			};
			// katakana 0x30F4..0x30FA
			tail_vowels = '{3, 1, 4, 1, 2, 4, 5};
		endfunction

		function vowel_t class_of(code_t c);
			if (c >= HIRA_START && c <= HIRA_TABLE_END)
				return vowel_t'(kana_vowels[int'(c - HIRA_START)]);
			if (c >= KATA_START && c <= KATA_TABLE_END)
				return vowel_t'(kana_vowels[int'(c - KATA_START)]);
			if (c >= KATA_CONV_END && c <= KATA_TAIL_END)
				return vowel_t'(tail_vowels[int'(c - KATA_CONV_END)]);
			return VOWEL_NONE;
		endfunction

		function void set_mode(dir_t d);
			mode = d;
		endfunction

		// Accepted input word: work out the converted point and queue it
		function void accept_code_point(code_t c, logic sot);
			code_t r;
			r = c;
			if (sot)
				last_vowel = VOWEL_NONE;
			if (mode == DIR_HIRA_TO_KATA) begin
				if (c >= HIRA_START && c <= HIRA_END)
					r = c + SCRIPT_OFFSET;
			end else if (c == SMALL_KA || c == SMALL_KE) begin
				r = c;
			end else if (c == PROLONGED_MARK) begin
				case (last_vowel)
					VOWEL_A: r = HIRA_A;
					VOWEL_I: r = HIRA_I;
					VOWEL_U, VOWEL_O: r = HIRA_U;
					VOWEL_E: r = HIRA_E;
					default: r = c;
				endcase
			end else if (c >= KATA_START && c <= KATA_CONV_END) begin
				r = c - SCRIPT_OFFSET;
			end
			last_vowel = class_of(r);
			expected_points.push_back(r);
		endfunction

		// Accepted output word: compare with the oldest prediction
		function void check_converted(code_t actual);
			code_t want;
			if (expected_points.size() == 0) begin
				$error("converted_point: expected none, actual %h", actual);
				errors++;
			end else begin
				want = expected_points.pop_front();
				if (want !== actual) begin
					$error("converted_point: expected %h, actual %h", want, actual);
					errors++;
				end
			end
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_stall;
	code_t code_point;
	logic  start_of_text;
	logic  out_valid;
	logic  out_stall;
	code_t converted_point;
	logic  cfg_valid;
	logic  cfg_ready;
	logic  direction;

	int sender_idle_pct = 0;
	int rx_stall_pct = 0;
	bit hold_req = 1'b0;
	int stuck_cycles = 0;

	kana_conversion_tracker sb = new();

	kana_script_converter u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.code_point      (code_point),
		.start_of_text   (start_of_text),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.converted_point (converted_point),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.direction       (direction)
	);

	// 20 ns clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Monitor: every accepted word goes to the tracker
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			sb.accept_code_point(code_point, start_of_text);
		if (out_valid && !out_stall)
			sb.check_converted(converted_point);
		if (cfg_valid && cfg_ready)
			sb.set_mode(dir_t'(direction));
	end

	// Watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// Receiver: random stall, or a long hold-off on request
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	// Offer one word, with random idle cycles ahead of it
	task automatic send_word(input code_t c, input logic sot);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		code_point <= c;
		start_of_text <= sot;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stop offering and wait until every predicted word has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_points.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_direction(input dir_t d);
		cfg_valid <= 1'b1;
		direction <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly kana and prolonged marks, some noise over the full 21 bits
	function automatic code_t random_point();
		case ($urandom_range(9))
			0, 1: return code_t'($urandom_range(21'h030A0, 21'h03038));
			2, 3: return code_t'($urandom_range(21'h03100, 21'h0309C));
			4, 5: return PROLONGED_MARK;
			6: return code_t'($urandom_range(21'h030FB, 21'h030F4));
			7: return code_t'($urandom);
			8: return code_t'($urandom_range(255, 0));
			default: return code_t'($urandom_range(21'h1FFFFF, 21'h10FFFF));
		endcase
	endfunction

	task automatic run_phase(input int tx_idle, input int rx_stall, input dir_t d,
			input bit hold_off, input bit mid_drain);
		wait_drained();
		sender_idle_pct = tx_idle;
		rx_stall_pct = rx_stall;
		write_direction(d);
		if (hold_off)
			hold_req = 1'b1;
		for (int i = 0; i < PHASE_WORDS; i++) begin
			// sender pauses once until the block is empty
			if (mid_drain && i == PHASE_WORDS / 2)
				wait_drained();
			send_word(random_point(), $urandom_range(15) == 0);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		code_point <= '0;
		start_of_text <= 1'b0;
		cfg_valid <= 1'b0;
		direction <= DIR_HIRA_TO_KATA;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: hiragana to katakana from reset, range edges and wide values
		send_word(21'h000000, 1'b1);
		send_word(21'h1FFFFF, 1'b0);
		send_word(21'h10FFFF, 1'b0);
		send_word(21'h03040, 1'b0);
		send_word(HIRA_START, 1'b0);
		send_word(HIRA_END, 1'b0);
		send_word(21'h03097, 1'b0);
		send_word(PROLONGED_MARK, 1'b0);
		send_word(21'h03044, 1'b0);
		wait_drained();

		// Directed: katakana to hiragana; first mark uses the class left by mode 0
		write_direction(DIR_KATA_TO_HIRA);
		send_word(PROLONGED_MARK, 1'b0);
		send_word(21'h030A0, 1'b0);
		send_word(KATA_START, 1'b0);
		send_word(PROLONGED_MARK, 1'b0);
		send_word(PROLONGED_MARK, 1'b0);
		send_word(KATA_CONV_END, 1'b0);
		send_word(PROLONGED_MARK, 1'b0);
		send_word(SMALL_KA, 1'b0);
		send_word(PROLONGED_MARK, 1'b0);
		send_word(SMALL_KE, 1'b0);
		send_word(PROLONGED_MARK, 1'b0);
		send_word(21'h030AA, 1'b0);
		send_word(PROLONGED_MARK, 1'b1);
		send_word(KATA_TAIL_END, 1'b0);
		send_word(PROLONGED_MARK, 1'b0);

		// Random phases over idle and stall patterns, a hold-off and both directions
		run_phase(0, 0, DIR_KATA_TO_HIRA, 1'b1, 1'b0);
		run_phase(69, 0, DIR_HIRA_TO_KATA, 1'b0, 1'b0);
		run_phase(0, 69, DIR_KATA_TO_HIRA, 1'b0, 1'b0);
		run_phase(36, 36, DIR_HIRA_TO_KATA, 1'b0, 1'b1);
		run_phase(0, 0, DIR_HIRA_TO_KATA, 1'b0, 1'b0);
		run_phase(69, 0, DIR_KATA_TO_HIRA, 1'b0, 1'b0);
		run_phase(0, 69, DIR_HIRA_TO_KATA, 1'b0, 1'b0);
		run_phase(36, 36, DIR_KATA_TO_HIRA, 1'b0, 1'b0);

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.expected_points.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
